[rtl/jsap_pkg.sv]
// ----------------------------------------------------------------------------
// jsap_pkg: shared types and codes for the JSON string array parser
// Phase codes, result kinds, error codes and the per-word step result.
// ----------------------------------------------------------------------------
package jsap_pkg;

  // Parse phase codes
  localparam logic [2:0] PH_BEFORE = 3'd0;
  localparam logic [2:0] PH_STRING = 3'd1;
  localparam logic [2:0] PH_ESCAPE = 3'd2;
  localparam logic [2:0] PH_AFTER  = 3'd3;
  localparam logic [2:0] PH_ERROR  = 3'd4;

  // Result kinds
  localparam logic [1:0] K_CHAR      = 2'd0;
  localparam logic [1:0] K_END_VALUE = 2'd1;
  localparam logic [1:0] K_ACCEPT    = 2'd2;
  localparam logic [1:0] K_ERROR     = 2'd3;

  // Error codes
  localparam logic [1:0] E_QUOTE  = 2'd0;
  localparam logic [1:0] E_COMMA  = 2'd1;
  localparam logic [1:0] E_ESCAPE = 2'd2;

  // Input actions
  localparam logic ACT_BYTE = 1'b0;
  localparam logic ACT_END  = 1'b1;

  // Characters of interest
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_COMMA  = 8'h2c;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] char_out;
    logic [1:0] error_code;
    logic       last;
  } result_t;

  typedef struct packed {
    logic [1:0] count;
    result_t    res0;
    result_t    res1;
    logic [2:0] phase;
  } step_t;

endpackage

[rtl/jsap_step.sv]
// ----------------------------------------------------------------------------
// jsap_step: one-word parse step
// Maps the current phase and one input word to the next phase and up to
// two result words.
// ----------------------------------------------------------------------------
module jsap_step (
  input  logic [2:0]      phase_i,
  input  logic            action_i,
  input  logic [7:0]      data_byte_i,
  output jsap_pkg::step_t step_o
);
  import jsap_pkg::*;

  logic       blank;
  logic [7:0] esc_char;
  result_t    r0;
  result_t    r1;
  logic [1:0] cnt;
  logic [2:0] ph_next;

  // Classify whitespace
  assign blank = (data_byte_i == 8'd32) ||
                 ((data_byte_i >= 8'd9) && (data_byte_i <= 8'd13));

  // Decode escaped character
  always_comb begin
    case (data_byte_i)
      8'h62:   esc_char = 8'd8;
      8'h66:   esc_char = 8'd12;
      8'h6e:   esc_char = 8'd10;
      8'h72:   esc_char = 8'd13;
      8'h74:   esc_char = 8'd9;
      default: esc_char = data_byte_i;
    endcase
  end

  // Advance phase and build results
  always_comb begin
    r0      = '0;
    r1      = '0;
    cnt     = 2'd0;
    ph_next = phase_i;
    if (action_i == ACT_END) begin
      ph_next = PH_BEFORE;
      if (phase_i == PH_STRING) begin
        r0.kind = K_END_VALUE;
        r1.kind = K_ACCEPT;
        cnt     = 2'd2;
      end else if (phase_i == PH_ESCAPE) begin
        r0.kind       = K_ERROR;
        r0.error_code = E_ESCAPE;
        cnt           = 2'd1;
      end else if (phase_i != PH_ERROR) begin
        r0.kind = K_ACCEPT;
        cnt     = 2'd1;
      end
    end else begin
      unique case (phase_i)
        PH_STRING: begin
          if (data_byte_i == CH_BSLASH) begin
            ph_next = PH_ESCAPE;
          end else if (data_byte_i == CH_QUOTE) begin
            r0.kind = K_END_VALUE;
            cnt     = 2'd1;
            ph_next = PH_AFTER;
          end else begin
            r0.kind     = K_CHAR;
            r0.char_out = data_byte_i;
            cnt         = 2'd1;
          end
        end
        PH_ESCAPE: begin
          r0.kind     = K_CHAR;
          r0.char_out = esc_char;
          cnt         = 2'd1;
          ph_next     = PH_STRING;
        end
        PH_AFTER: begin
          if (data_byte_i == CH_COMMA) begin
            ph_next = PH_BEFORE;
          end else if (!blank) begin
            r0.kind       = K_ERROR;
            r0.error_code = E_COMMA;
            cnt           = 2'd1;
            ph_next       = PH_ERROR;
          end
        end
        PH_ERROR: begin
          ph_next = PH_ERROR;
        end
        default: begin
          if (data_byte_i == CH_QUOTE) begin
            ph_next = PH_STRING;
          end else if (!blank) begin
            r0.kind       = K_ERROR;
            r0.error_code = E_QUOTE;
            cnt           = 2'd1;
            ph_next       = PH_ERROR;
          end else begin
            ph_next = PH_BEFORE;
          end
        end
      endcase
    end
    // Mark the final result of this word
    if (cnt == 2'd1) begin
      r0.last = 1'b1;
    end else if (cnt == 2'd2) begin
      r1.last = 1'b1;
    end
  end

  assign step_o.count = cnt;
  assign step_o.res0  = r0;
  assign step_o.res1  = r1;
  assign step_o.phase = ph_next;

endmodule

[rtl/json_string_array_parser.sv]
// A word accepted into the input register is parsed and written into the result queue, whose head drives the outputs.
// Throughput: one input word per cycle unless the input is stalled; an end mark inside a
// string adds a second result, which takes one more entry of the four-entry queue.
// Input is stalled only when the queue lacks room for two result words.
// Reset (rst_ni low, asynchronous) clears the phase, input valid and queue.
// ----------------------------------------------------------------------------
// json_string_array_parser: JSON string array body tokenizer
// Input register, one-word parse step, and a small result queue.
// ----------------------------------------------------------------------------
module json_string_array_parser (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       action_i,
  input  logic [7:0] data_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] kind_o,
  output logic [7:0] char_out_o,
  output logic [1:0] error_code_o,
  output logic       last_o
);
  import jsap_pkg::*;

  logic       in_valid_q;
  logic       action_q;
  logic [7:0] data_byte_q;
  logic [2:0] phase_q;
  result_t    fifo_q [4];
  logic [1:0] rd_ptr_q;
  logic [1:0] wr_ptr_q;
  logic [2:0] count_q;
  logic [2:0] count_d;
  step_t      step;
  logic       advance;
  logic       pop;
  logic       in_take;
  logic [1:0] wr_n;
  result_t    head;

  // Parse one word
  jsap_step u_step (
    .phase_i    (phase_q),
    .action_i   (action_q),
    .data_byte_i(data_byte_q),
    .step_o     (step)
  );

  // Move a word into the queue when two slots are free
  assign advance    = in_valid_q && (count_q <= 3'd2);
  assign in_stall_o = in_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;
  assign pop        = out_valid_o && !out_stall_i;
  assign wr_n       = advance ? step.count : 2'd0;
  assign count_d    = count_q + {1'b0, wr_n} - {2'b00, pop};

  // Hold the input word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      action_q    <= action_i;
      data_byte_q <= data_byte_i;
    end
  end

  // Advance parse phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_BEFORE;
    end else if (advance) begin
      phase_q <= step.phase;
    end
  end

  // Queue pointers and fill
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q <= 2'd0;
      wr_ptr_q <= 2'd0;
      count_q  <= 3'd0;
    end else begin
      count_q  <= count_d;
      wr_ptr_q <= wr_ptr_q + wr_n;
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 2'd1;
      end
    end
  end

  // Queue storage
  always_ff @(posedge clk_i) begin
    if (wr_n != 2'd0) begin
      fifo_q[wr_ptr_q] <= step.res0;
    end
    if (wr_n == 2'd2) begin
      fifo_q[wr_ptr_q + 2'd1] <= step.res1;
    end
  end

  // Present the head word
  assign head         = fifo_q[rd_ptr_q];
  assign out_valid_o  = (count_q != 3'd0);
  assign kind_o       = head.kind;
  assign char_out_o   = head.char_out;
  assign error_code_o = head.error_code;
  assign last_o       = head.last;

endmodule

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb: testbench for the JSON string array parser
// Drives array bodies word by word with random gaps and output stalls, works
// out the token stream each word should give, and checks every result word.
// ----------------------------------------------------------------------------
module tb;
  import jsap_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_WORDS = 270;

  // Escape letters and the control codes they stand for
  localparam logic [7:0] ESC_B = 8'h62;
  localparam logic [7:0] ESC_F = 8'h66;
  localparam logic [7:0] ESC_N = 8'h6e;
  localparam logic [7:0] ESC_R = 8'h72;
  localparam logic [7:0] ESC_T = 8'h74;
  localparam logic [7:0] CTL_BACKSPACE = 8'h08;
  localparam logic [7:0] CTL_FORMFEED  = 8'h0c;
  localparam logic [7:0] CTL_NEWLINE   = 8'h0a;
  localparam logic [7:0] CTL_RETURN    = 8'h0d;
  localparam logic [7:0] CTL_TAB       = 8'h09;
  localparam logic [7:0] CH_SPACE      = 8'h20;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic       action_i = ACT_BYTE;
  logic [7:0] data_byte_i = 8'h00;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [1:0] kind_o;
  logic [7:0] char_out_o;
  logic [1:0] error_code_o;
  logic       last_o;

  result_t    token_q [$];
  logic [2:0] tok_phase = PH_BEFORE;
  int         fail_count = 0;
  int         words_sent = 0;
  int         cycle_count = 0;
  int         send_idle_pct = 0;
  int         recv_stall_pct = 0;
  int         hold_left = 0;

  json_string_array_parser uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .action_i     (action_i),
    .data_byte_i  (data_byte_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .kind_o       (kind_o),
    .char_out_o   (char_out_o),
    .error_code_o (error_code_o),
    .last_o       (last_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Stop a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Advance the token state by one word and queue the tokens it yields
  task automatic tokenize_word(input logic act, input logic [7:0] b);
    result_t res [2];
    int      n;
    logic    blank;
    n = 0;
    blank = (b == CH_SPACE) || (b >= CTL_TAB && b <= CTL_RETURN);
    res[0] = '0;
    res[1] = '0;
    if (act == ACT_END) begin
      case (tok_phase)
        PH_STRING: begin
          res[0].kind = K_END_VALUE;
          res[1].kind = K_ACCEPT;
          n = 2;
        end
        PH_ESCAPE: begin
          res[0].kind = K_ERROR;
          res[0].error_code = E_ESCAPE;
          n = 1;
        end
        PH_ERROR: n = 0;
        default: begin
          res[0].kind = K_ACCEPT;
          n = 1;
        end
      endcase
      tok_phase = PH_BEFORE;
    end else begin
      case (tok_phase)
        PH_STRING: begin
          if (b == CH_BSLASH) begin
            tok_phase = PH_ESCAPE;
          end else if (b == CH_QUOTE) begin
            res[0].kind = K_END_VALUE;
            n = 1;
            tok_phase = PH_AFTER;
          end else begin
            res[0].kind = K_CHAR;
            res[0].char_out = b;
            n = 1;
          end
        end
        PH_ESCAPE: begin
          res[0].kind = K_CHAR;
          case (b)
            ESC_B:   res[0].char_out = CTL_BACKSPACE;
            ESC_F:   res[0].char_out = CTL_FORMFEED;
            ESC_N:   res[0].char_out = CTL_NEWLINE;
            ESC_R:   res[0].char_out = CTL_RETURN;
            ESC_T:   res[0].char_out = CTL_TAB;
            default: res[0].char_out = b;
          endcase
          n = 1;
          tok_phase = PH_STRING;
        end
        PH_AFTER: begin
          if (b == CH_COMMA) begin
            tok_phase = PH_BEFORE;
          end else if (!blank) begin
            res[0].kind = K_ERROR;
            res[0].error_code = E_COMMA;
            n = 1;
            tok_phase = PH_ERROR;
          end
        end
        PH_ERROR: n = 0;
        default: begin
          if (b == CH_QUOTE) begin
            tok_phase = PH_STRING;
          end else if (!blank) begin
            res[0].kind = K_ERROR;
            res[0].error_code = E_QUOTE;
            n = 1;
            tok_phase = PH_ERROR;
          end else begin
            tok_phase = PH_BEFORE;
          end
        end
      endcase
    end
    for (int i = 0; i < n; i++) begin
      res[i].last = (i == n - 1);
      token_q = {token_q, res[i]};
    end
  endtask

  // Offer one word after a random gap, hold it until taken
  task automatic send_word(input logic act, input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i <= act;
    data_byte_i <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    tokenize_word(act, b);
    words_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_word(ACT_BYTE, s[i]);
  endtask

  task automatic send_end();
    send_word(ACT_END, 8'($urandom_range(0, 255)));
  endtask

  // Bias toward the bytes the parser treats specially
  function automatic logic [7:0] noise_byte();
    case ($urandom_range(0, 7))
      0:       return CH_QUOTE;
      1:       return CH_BSLASH;
      2:       return CH_COMMA;
      3:       return CH_SPACE;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [7:0] blank_byte();
    logic [7:0] b;
    b = 8'($urandom_range(8, 13));
    return (b == 8'd8) ? CH_SPACE : b;
  endfunction

  function automatic logic [7:0] escape_letter();
    case ($urandom_range(0, 6))
      0:       return ESC_B;
      1:       return ESC_F;
      2:       return ESC_N;
      3:       return ESC_R;
      4:       return ESC_T;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // One body: mostly well-formed with random content, some broken, some noise
  task automatic send_random_body();
    int         shape;
    int         nvals;
    int         bad_at;
    logic [7:0] b;
    shape = $urandom_range(0, 99);
    if (shape < 12) begin
      repeat ($urandom_range(1, 12)) send_word(ACT_BYTE, noise_byte());
      send_end();
    end else begin
      nvals = $urandom_range(0, 4);
      bad_at = (shape < 24) ? int'($urandom_range(0, nvals)) : -1;
      for (int v = 0; v < nvals; v++) begin
        if (v == bad_at) send_word(ACT_BYTE, noise_byte());
        repeat ($urandom_range(0, 2)) send_word(ACT_BYTE, blank_byte());
        send_word(ACT_BYTE, CH_QUOTE);
        repeat ($urandom_range(0, 6)) begin
          if ($urandom_range(0, 9) < 2) begin
            send_word(ACT_BYTE, CH_BSLASH);
            send_word(ACT_BYTE, escape_letter());
          end else begin
            b = 8'($urandom_range(0, 255));
            send_word(ACT_BYTE, (b == CH_QUOTE || b == CH_BSLASH) ? 8'h61 : b);
          end
        end
        // Leave the last value open now and then, sometimes mid-escape
        if (v == nvals - 1 && $urandom_range(0, 99) < 14) begin
          if ($urandom_range(0, 1) == 1) send_word(ACT_BYTE, CH_BSLASH);
        end else begin
          send_word(ACT_BYTE, CH_QUOTE);
          repeat ($urandom_range(0, 2)) send_word(ACT_BYTE, blank_byte());
          if (v < nvals - 1 || $urandom_range(0, 99) < 15) send_word(ACT_BYTE, CH_COMMA);
        end
      end
      if (bad_at == nvals) send_word(ACT_BYTE, noise_byte());
      send_end();
    end
  endtask

  // Check each word taken from the output against the oldest queued token
  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk_i) begin : result_monitor
    result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (token_q.size() == 0) begin
        $display("%0t: unexpected word, expected none, got kind %0d char %0h err %0d last %0b",
                 $time, kind_o, char_out_o, error_code_o, last_o);
        fail_count++;
      end else begin
        want = token_q.pop_front();
        check_field("kind", 8'(want.kind), 8'(kind_o));
        check_field("char_out", want.char_out, char_out_o);
        check_field("error_code", 8'(want.error_code), 8'(error_code_o));
        check_field("last", 8'(want.last), 8'(last_o));
      end
    end
    // Hold off for a counted stretch when asked, else stall at random
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left = hold_left - 1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Values with extreme bytes, escapes and a trailing comma
  task automatic test_well_formed();
    send_end();
    send_word(ACT_BYTE, CH_QUOTE);
    send_word(ACT_BYTE, 8'h00);
    send_word(ACT_BYTE, 8'hff);
    send_text("\\b\\\"\",");
    send_end();
  endtask

  // Unterminated last string and a dangling escape
  task automatic test_special_endings();
    send_word(ACT_BYTE, CTL_RETURN);
    send_text("\"\\f\\n\\r\\t\\\\");
    send_end();
    send_text("\"\\");
    send_end();
  endtask

  // Missing quote, missing comma, and bytes swallowed after an error
  task automatic test_wrong_bytes();
    send_text("xa");
    send_end();
    send_text("\"\" z");
    send_end();
  endtask

  // Long output hold-off while a long string keeps the input busy
  task automatic test_long_holdoff();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_left = 120;
    send_word(ACT_BYTE, CH_QUOTE);
    repeat (40) send_word(ACT_BYTE, 8'($urandom_range(8'h30, 8'h7a)));
    send_word(ACT_BYTE, CH_QUOTE);
    send_end();
  endtask

  task automatic test_random_bodies(input int idle_pct, input int stall_pct);
    int stop_at;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    stop_at = words_sent + RANDOM_WORDS;
    while (words_sent < stop_at) send_random_body();
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_well_formed();
    test_special_endings();
    test_wrong_bytes();
    test_long_holdoff();
    test_random_bodies(0, 0);
    test_random_bodies(60, 0);
    test_random_bodies(0, 60);
    test_random_bodies(26, 26);
    in_valid_i <= 1'b0;
    // Drain the output, then wait a while longer for stray words
    while (token_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
